### rtl/csl_pkg.sv
// Package with the shared types, codes and keyword table of the C subset lexer.
`timescale 1ns / 1ps
package csl_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [4:0]  token_code;
        logic [6:0]  ident_address;
        logic [15:0] line_number;
        logic [31:0] start_offset;
        logic [5:0]  token_length;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUM    = 3'd2,
        MODE_NUMDOT = 3'd3,
        MODE_FRAC   = 3'd4,
        MODE_STR    = 3'd5,
        MODE_CHR    = 3'd6,
        MODE_OP     = 3'd7
    } lex_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_INSERT,
        ST_OUT1,
        ST_OUT2
    } seq_state_t;

    localparam logic [3:0] KIND_KEYWORD = 4'd0;
    localparam logic [3:0] KIND_IDENT   = 4'd1;
    localparam logic [3:0] KIND_INT     = 4'd2;
    localparam logic [3:0] KIND_FLOAT   = 4'd3;
    localparam logic [3:0] KIND_CHAR    = 4'd4;
    localparam logic [3:0] KIND_STRING  = 4'd5;
    localparam logic [3:0] KIND_OPER    = 4'd6;
    localparam logic [3:0] KIND_SEP     = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;

    localparam logic [4:0] ERR_FLOAT      = 5'd1;
    localparam logic [4:0] ERR_TABLE_FULL = 5'd2;
    localparam logic [4:0] ERR_OPEN_STR   = 5'd4;
    localparam logic [4:0] ERR_OPEN_CHR   = 5'd5;
    localparam logic [4:0] ERR_ILLEGAL    = 5'd6;

    localparam int KW_COUNT = 15;

    function automatic logic [63:0] kw_text(input logic [3:0] k);
        logic [63:0] t;
        t = 64'd0;
        case (k)
            4'd0:  t = {24'd0, "kaerb"};
            4'd1:  t = {32'd0, "rahc"};
            4'd2:  t = "eunitnoc";
            4'd3:  t = {32'd0, "esle"};
            4'd4:  t = {24'd0, "taolf"};
            4'd5:  t = {40'd0, "rof"};
            4'd6:  t = {48'd0, "fi"};
            4'd7:  t = {40'd0, "tni"};
            4'd8:  t = {16'd0, "nruter"};
            4'd9:  t = {32'd0, "diov"};
            4'd10: t = {24'd0, "elihw"};
            4'd11: t = "ebircsed";
            4'd12: t = {16'd0, "gnirts"};
            4'd13: t = {24'd0, "tigid"};
            4'd14: t = {32'd0, "niam"};
            default: t = 64'd0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            4'd0, 4'd4, 4'd10, 4'd13: n = 4'd5;
            4'd1, 4'd3, 4'd9, 4'd14:  n = 4'd4;
            4'd2, 4'd11:              n = 4'd8;
            4'd5, 4'd7:               n = 4'd3;
            4'd6:                     n = 4'd2;
            4'd8, 4'd12:              n = 4'd6;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] pair_code(input logic [7:0] f, input logic [7:0] s);
        logic [5:0] p;
        p = 6'h3F;
        if (s == "=") begin
            case (f)
                "-": p = 6'd17;
                "+": p = 6'd16;
                "*": p = 6'd18;
                "%": p = 6'd20;
                "/": p = 6'd19;
                "<": p = 6'd10;
                ">": p = 6'd11;
                "=": p = 6'd12;
                default: p = 6'h3F;
            endcase
        end else if (f == s) begin
            case (f)
                "-": p = 6'd9;
                "+": p = 6'd8;
                "&": p = 6'd14;
                "|": p = 6'd15;
                default: p = 6'h3F;
            endcase
        end
        return p;
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] f);
        logic [5:0] s;
        case (f)
            "*": s = 6'd0;
            "/": s = 6'd1;
            "%": s = 6'd2;
            "+": s = 6'd3;
            "-": s = 6'd4;
            "<": s = 6'd5;
            ">": s = 6'd6;
            "=": s = 6'd7;
            default: s = 6'h3F;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] sep_code(input logic [7:0] c);
        logic [5:0] s;
        case (c)
            "(": s = 6'd0;
            ")": s = 6'd1;
            "[": s = 6'd2;
            "]": s = 6'd3;
            "{": s = 6'd4;
            "}": s = 6'd5;
            ".": s = 6'd6;
            ",": s = 6'd7;
            ";": s = 6'd8;
            default: s = 6'h3F;
        endcase
        return s;
    endfunction

endpackage

### rtl/c_subset_lexer_top.sv
// Top level of the C subset lexer: scanner state, keyword check and output staging.
`timescale 1ns / 1ps
// Channel  | Direction | Payload     | Handshake
// in       | input     | in_item_t   | in_valid / in_stall
// out      | output    | out_item_t  | out_valid / out_stall
// Most characters are accepted in ST_IDLE and scanned in ST_CHECK; results then leave in ST_OUT1 and ST_OUT2.
// Finishing an identifier searches the table memory one stored entry at a time, with a read
// state and a check state per entry, and inserts the key when no entry matches and there is room.
// Reset clears the scanner state, offset and table fill count and sets the line counter to one.
// A stall on the output holds the result and blocks the input until it drains.
module c_subset_lexer_top
    import csl_pkg::*;
#(
    parameter int MAX_TOKEN     = 32,
    parameter int IDENT_ENTRIES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int WORDS = (MAX_TOKEN + 7) / 8;
    localparam int LEN_W = $clog2(MAX_TOKEN + 1);
    localparam int POS_W = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;

    seq_state_t           state_reg, state_next;
    lex_mode_t            mode_reg, mode_next;
    logic [WORDS*64-1:0]  buf_reg, buf_next;
    logic [LEN_W-1:0]     count_reg, count_next;
    logic [15:0]          line_reg, line_next;
    logic [31:0]          offset_reg, offset_next;
    logic [31:0]          start_reg, start_next;
    out_item_t            r1_reg, r1_next;
    out_item_t            r2_reg, r2_next;
    logic                 has2_reg, has2_next;
    logic [7:0]           pend_char_reg, pend_char_next;
    logic                 pend_eoi_reg, pend_eoi_next;
    logic                 tab_start;
    logic                 tab_done;
    logic                 tab_full;
    logic [6:0]           tab_addr;

    csl_ident_table #(
        .WORDS   (WORDS),
        .ENTRIES (IDENT_ENTRIES),
        .LEN_W   (LEN_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tab_start),
        .key     (buf_reg),
        .key_len (count_reg),
        .done    (tab_done),
        .full    (tab_full),
        .address (tab_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            line_reg   <= 16'd1;
            offset_reg <= '0;
            start_reg  <= '0;
            has2_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            line_reg   <= line_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            has2_reg   <= has2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        r1_reg        <= r1_next;
        r2_reg        <= r2_next;
        pend_char_reg <= pend_char_next;
        pend_eoi_reg  <= pend_eoi_next;
    end

    function automatic out_item_t mk(input logic [3:0] kind, input logic [4:0] code,
                                     input logic [6:0] addr, input logic [15:0] ln,
                                     input logic [31:0] st, input logic [LEN_W-1:0] len);
        out_item_t r;
        r.token_kind    = kind;
        r.token_code    = code;
        r.ident_address = addr;
        r.line_number   = ln;
        r.start_offset  = st;
        r.token_length  = 6'(len);
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Keyword match against the constant table.
    logic       kw_hit;
    logic [4:0] kw_code;
    logic [63:0] low_word;
    assign low_word = buf_reg[63:0];

    always_comb
    begin
        logic [63:0] mask;
        kw_hit  = 1'b0;
        kw_code = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            mask = (64'd1 << (8 * kw_len(4'(k)))) - 64'd1;
            if (kw_len(4'(k)) == count_reg && count_reg <= LEN_W'(8)
                && (low_word & mask) == kw_text(4'(k)) && !kw_hit)
            begin
                kw_hit  = 1'b1;
                kw_code = 5'(k + 1);
            end
        end
    end

    // Scan of one character; the pending identifier case is split off to the table.
    always_comb
    begin
        logic [7:0]       c;
        logic             eoi;
        logic             consumed;
        logic             n_emit;
        out_item_t        e [2];
        logic [5:0]       p;
        logic [5:0]       s;
        logic [7:0]       first;
        logic [31:0]      pos;
        logic             line_inc;

        state_next     = state_reg;
        mode_next      = mode_reg;
        buf_next       = buf_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        has2_next      = has2_reg;
        pend_char_next = pend_char_reg;
        pend_eoi_next  = pend_eoi_reg;
        tab_start      = 1'b0;
        in_stall       = 1'b1;
        out_valid      = 1'b0;
        out_data       = r1_reg;

        c        = pend_char_reg;
        eoi      = pend_eoi_reg;
        consumed = 1'b0;
        n_emit   = 1'b0;
        e[0]     = r1_reg;
        e[1]     = r2_reg;
        first    = buf_reg[7:0];
        pos      = offset_reg;
        line_inc = 1'b0;
        p        = '0;
        s        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    c   = in_data.char_code;
                    eoi = in_data.end_of_input;
                    pend_char_next = c;
                    pend_eoi_next  = eoi;
                    if (mode_reg == MODE_IDENT && !kw_hit
                        && (eoi || !(is_alpha(c) || is_digit(c))))
                    begin
                        tab_start  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tab_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Finish a pending token, then scan the character; at end of input, emit the end mark instead.
                if (eoi)
                begin
                    case (mode_reg)
                        MODE_IDENT:
                        begin
                            if (kw_hit)
                                e[0] = mk(KIND_KEYWORD, kw_code, 7'd0, line_reg, start_reg,
                                          count_reg);
                            else if (tab_full)
                                e[0] = mk(KIND_ERROR, ERR_TABLE_FULL, 7'd0, line_reg,
                                          start_reg, count_reg);
                            else
                                e[0] = mk(KIND_IDENT, 5'd0, tab_addr, line_reg, start_reg,
                                          count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_NUM:
                        begin
                            e[0] = mk(KIND_INT, 5'd0, 7'd0, line_reg, start_reg, count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_NUMDOT:
                        begin
                            e[0] = mk(KIND_ERROR, ERR_FLOAT, 7'd0, line_reg, start_reg,
                                      count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_FRAC:
                        begin
                            e[0] = mk(KIND_FLOAT, 5'd0, 7'd0, line_reg, start_reg,
                                      count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_STR:
                        begin
                            e[0] = mk(KIND_ERROR, ERR_OPEN_STR, 7'd0, line_reg, start_reg,
                                      count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_CHR:
                        begin
                            e[0] = mk(KIND_ERROR, ERR_OPEN_CHR, 7'd0, line_reg, start_reg,
                                      count_reg);
                            n_emit = 1'b1;
                        end
                        MODE_OP:
                        begin
                            s = single_code(first);
                            if (s != 6'h3F)
                                e[0] = mk(KIND_OPER, 5'(s), 7'd0, line_reg, start_reg,
                                          LEN_W'(1));
                            else
                                e[0] = mk(KIND_ERROR, ERR_ILLEGAL, 7'd0, line_reg,
                                          start_reg, LEN_W'(1));
                            n_emit = 1'b1;
                        end
                        default:
                        begin
                            n_emit = 1'b0;
                        end
                    endcase
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                    if (n_emit)
                    begin
                        e[1] = mk(KIND_END, 5'd0, 7'd0, line_reg, offset_reg, LEN_W'(0));
                        e[1].last_of_run = 1'b1;
                        r1_next   = e[0];
                        r2_next   = e[1];
                        has2_next = 1'b1;
                    end
                    else
                    begin
                        e[0] = mk(KIND_END, 5'd0, 7'd0, line_reg, offset_reg, LEN_W'(0));
                        e[0].last_of_run = 1'b1;
                        r1_next   = e[0];
                        has2_next = 1'b0;
                    end
                    state_next = ST_OUT1;
                end
                else
                begin
                    offset_next = offset_reg + 32'd1;
                    case (mode_reg)
                        MODE_IDENT:
                        begin
                            if (is_alpha(c) || is_digit(c))
                                consumed = 1'b1;
                            else
                            begin
                                if (kw_hit)
                                    e[0] = mk(KIND_KEYWORD, kw_code, 7'd0, line_reg,
                                              start_reg, count_reg);
                                else if (tab_full)
                                    e[0] = mk(KIND_ERROR, ERR_TABLE_FULL, 7'd0, line_reg,
                                              start_reg, count_reg);
                                else
                                    e[0] = mk(KIND_IDENT, 5'd0, tab_addr, line_reg,
                                              start_reg, count_reg);
                                n_emit = 1'b1;
                            end
                        end
                        MODE_NUM:
                        begin
                            if (is_digit(c))
                                consumed = 1'b1;
                            else if (c == ".")
                            begin
                                consumed  = 1'b1;
                                mode_next = MODE_NUMDOT;
                            end
                            else
                            begin
                                e[0] = mk(KIND_INT, 5'd0, 7'd0, line_reg, start_reg,
                                          count_reg);
                                n_emit = 1'b1;
                            end
                        end
                        MODE_NUMDOT, MODE_FRAC:
                        begin
                            if (is_digit(c))
                            begin
                                consumed  = 1'b1;
                                mode_next = MODE_FRAC;
                            end
                            else
                            begin
                                if (mode_reg == MODE_NUMDOT)
                                    e[0] = mk(KIND_ERROR, ERR_FLOAT, 7'd0, line_reg,
                                              start_reg, count_reg);
                                else
                                    e[0] = mk(KIND_FLOAT, 5'd0, 7'd0, line_reg, start_reg,
                                              count_reg);
                                n_emit = 1'b1;
                            end
                        end
                        MODE_STR, MODE_CHR:
                        begin
                            if ((mode_reg == MODE_STR && c == "\"")
                                || (mode_reg == MODE_CHR && c == "'"))
                            begin
                                e[0] = mk((mode_reg == MODE_STR) ? KIND_STRING : KIND_CHAR,
                                          5'd0, 7'd0, line_reg, start_reg, count_reg);
                                n_emit     = 1'b1;
                                mode_next  = MODE_IDLE;
                                count_next = '0;
                                state_next = ST_OUT1;
                            end
                            else
                            begin
                                consumed = 1'b1;
                                if (c == "\n")
                                    line_inc = 1'b1;
                            end
                        end
                        MODE_OP:
                        begin
                            p = pair_code(first, c);
                            if (first == "-" && is_digit(c))
                            begin
                                consumed  = 1'b1;
                                mode_next = MODE_NUM;
                            end
                            else if (p != 6'h3F)
                            begin
                                e[0] = mk(KIND_OPER, 5'(p), 7'd0, line_reg, start_reg,
                                          LEN_W'(2));
                                n_emit     = 1'b1;
                                mode_next  = MODE_IDLE;
                                count_next = '0;
                            end
                            else
                            begin
                                s = single_code(first);
                                if (s != 6'h3F)
                                    e[0] = mk(KIND_OPER, 5'(s), 7'd0, line_reg, start_reg,
                                              LEN_W'(1));
                                else
                                    e[0] = mk(KIND_ERROR, ERR_ILLEGAL, 7'd0, line_reg,
                                              start_reg, LEN_W'(1));
                                n_emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            consumed = 1'b0;
                        end
                    endcase

                    if (consumed)
                    begin
                        if (count_reg < LEN_W'(MAX_TOKEN))
                        begin
                            buf_next[8*count_reg[POS_W-1:0] +: 8] = c;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (!(mode_reg == MODE_OP && p != 6'h3F)
                             && !((mode_reg == MODE_STR || mode_reg == MODE_CHR)))
                    begin
                        // The character was not taken by a pending token: scan it fresh.
                        mode_next  = MODE_IDLE;
                        count_next = '0;
                        buf_next   = '0;
                        if (is_alpha(c) || is_digit(c))
                        begin
                            mode_next   = is_alpha(c) ? MODE_IDENT : MODE_NUM;
                            start_next  = pos;
                            buf_next[7:0] = c;
                            count_next  = LEN_W'(1);
                        end
                        else if (c == "\"" || c == "'")
                        begin
                            start_next = pos + 32'd1;
                            mode_next  = (c == "\"") ? MODE_STR : MODE_CHR;
                        end
                        else if (c == " " || c == "\t" || c == "\r")
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else if (c == "\n")
                        begin
                            line_inc = 1'b1;
                        end
                        else if (c == "-" || c == "+" || c == "*" || c == "%" || c == "/"
                                 || c == "&" || c == "|" || c == "<" || c == ">"
                                 || c == "=")
                        begin
                            mode_next     = MODE_OP;
                            start_next    = pos;
                            buf_next[7:0] = c;
                            count_next    = LEN_W'(1);
                        end
                        else
                        begin
                            s = sep_code(c);
                            if (s != 6'h3F)
                                e[n_emit] = mk(KIND_SEP, 5'(s), 7'd0, line_reg, pos,
                                               LEN_W'(1));
                            else
                                e[n_emit] = mk(KIND_ERROR, ERR_ILLEGAL, 7'd0, line_reg, pos,
                                               LEN_W'(1));
                            if (n_emit)
                            begin
                                e[1].last_of_run = 1'b1;
                                r1_next   = e[0];
                                r2_next   = e[1];
                                has2_next = 1'b1;
                                state_next = ST_OUT1;
                            end
                            else
                            begin
                                e[0].last_of_run = 1'b1;
                                r1_next   = e[0];
                                has2_next = 1'b0;
                                state_next = ST_OUT1;
                            end
                            n_emit = 1'b0;
                        end
                    end

                    if (n_emit)
                    begin
                        e[0].last_of_run = 1'b1;
                        r1_next    = e[0];
                        has2_next  = 1'b0;
                        state_next = ST_OUT1;
                    end
                    else if (state_next == ST_CHECK)
                    begin
                        state_next = ST_IDLE;
                    end

                    if (line_inc && line_reg != 16'hFFFF)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                end
            end
            ST_OUT1:
            begin
                out_valid = 1'b1;
                out_data  = r1_reg;
                if (!out_stall)
                begin
                    state_next = has2_reg ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2:
            begin
                out_valid = 1'b1;
                out_data  = r2_reg;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
        else $error("line counter reached zero");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(MAX_TOKEN))
        else $error("token length beyond buffer");
    a_search_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_SEARCH) |-> $past(in_valid) && $past(mode_reg == MODE_IDENT))
        else $error("table search without a pending identifier");
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT2) |-> r2_reg.last_of_run && !r1_reg.last_of_run)
        else $error("last mark misplaced on a two-result transaction");
`endif

endmodule

### rtl/csl_ident_table.sv
// Identifier table memory with a sequential search and insert unit.
`timescale 1ns / 1ps
module csl_ident_table
    import csl_pkg::*;
#(
    parameter int WORDS   = 4,
    parameter int ENTRIES = 64,
    parameter int LEN_W   = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [WORDS*64-1:0]     key,
    input  logic [LEN_W-1:0]        key_len,
    output logic                    done,
    output logic                    full,
    output logic [6:0]              address
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ROW_W = WORDS * 64 + LEN_W + 7;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CHECK
    } tab_state_t;

    logic [ROW_W-1:0] mem [ENTRIES];
    logic [ROW_W-1:0] rd_data_reg;

    tab_state_t       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] entries_reg, entries_next;
    logic [6:0]       addr_ctr_reg, addr_ctr_next;
    logic             done_reg, done_next;
    logic             full_reg, full_next;
    logic [6:0]       address_reg, address_next;
    logic             wr_en;
    logic [IDX_W-1:0] rd_idx;
    logic [ROW_W-1:0] wr_row;

    assign rd_idx = idx_reg[IDX_W-1:0];
    assign wr_row = {key, key_len, addr_ctr_reg + 7'd1};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[entries_reg[IDX_W-1:0]] <= wr_row;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            idx_reg      <= '0;
            entries_reg  <= '0;
            addr_ctr_reg <= '0;
            done_reg     <= 1'b0;
            full_reg     <= 1'b0;
            address_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            entries_reg  <= entries_next;
            addr_ctr_reg <= addr_ctr_next;
            done_reg     <= done_next;
            full_reg     <= full_next;
            address_reg  <= address_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        entries_next  = entries_reg;
        addr_ctr_next = addr_ctr_reg;
        done_next     = 1'b0;
        full_next     = full_reg;
        address_next  = address_reg;
        wr_en         = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = T_READ;
                end
            end
            T_READ:
            begin
                if (idx_reg == entries_reg)
                begin
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                    if (entries_reg == CNT_W'(ENTRIES))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        full_next     = 1'b0;
                        wr_en         = 1'b1;
                        addr_ctr_next = addr_ctr_reg + 7'd1;
                        address_next  = addr_ctr_reg + 7'd1;
                        entries_next  = entries_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (rd_data_reg[ROW_W-1:7] == {key, key_len})
                begin
                    full_next    = 1'b0;
                    address_next = rd_data_reg[6:0];
                    done_next    = 1'b1;
                    state_next   = T_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = T_READ;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign done    = done_reg;
    assign full    = full_reg;
    assign address = address_reg;

`ifndef NO_ASSERTIONS
    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");
    a_write_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> done_reg && !full_reg)
        else $error("insert without completion");
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");
`endif

endmodule
